[hw/rtl/fra_pkg.sv]
package fra_pkg;

    // header layout: image (4 bytes), sequence (4 bytes), last flag (1 byte)
    localparam int HDR_LEN = 9;
    localparam int HDR_IW  = 4;

    localparam int MAX_PAYLOAD_DEF = 1024;
    localparam int FRAGMENTS_DEF   = 32;
    localparam int SLOTS_DEF       = 4;

    localparam logic [31:0] WINDOW_RESET = 32'd8;

    // slot status codes
    typedef enum logic [1:0] {
        ST_FREE       = 2'd0,
        ST_ASSEMBLING = 2'd1,
        ST_READY      = 2'd2
    } slot_status_t;

    // drop reasons
    localparam logic [2:0] DROP_NONE      = 3'd0;
    localparam logic [2:0] DROP_SHORT     = 3'd1;
    localparam logic [2:0] DROP_BAD_SEQ   = 3'd2;
    localparam logic [2:0] DROP_OVERSIZE  = 3'd3;
    localparam logic [2:0] DROP_NO_SLOT   = 3'd4;

    // input actions and result kinds
    localparam logic ACT_BYTE   = 1'b0;
    localparam logic ACT_TICK   = 1'b1;
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_DROP  = 1'b1;

    // register indexes
    localparam logic REG_WINDOW = 1'b0;

endpackage

[hw/rtl/fra_ram.sv]
module fra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/fragment_reassembler.sv]
// Packet byte: S_IDLE; the ninth header byte adds eviction and slot lookup (S_EVICT, S_ALLOC)
// and the end byte S_END to record the fragment, then S_EMIT for a drop notice. Output tick:
// idle on an empty queue, else S_FIND per absent sequence, S_FIND and S_FCHK per present one,
// S_FIND when the scan runs off the end, S_PCAP to fetch the payload and S_EMIT to load the
// result register, which holds the block while a beat waits. One item is in flight at a time.
// rst_n (asynchronous, active low) frees every slot, empties the queue, sets the window to 8.
module fragment_reassembler #(
    parameter int MAX_PAYLOAD = fra_pkg::MAX_PAYLOAD_DEF,
    parameter int FRAGMENTS   = fra_pkg::FRAGMENTS_DEF,
    parameter int SLOTS       = fra_pkg::SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [7:0]  data_byte,
    input  logic        packet_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        out_kind,
    output logic [7:0]  out_byte,
    output logic        frame_last,
    output logic [31:0] frame_image,
    output logic [2:0]  drop_reason,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int HDR    = fra_pkg::HDR_LEN;
    localparam int HIW    = fra_pkg::HDR_IW;
    localparam int POS_W  = $clog2(HDR + MAX_PAYLOAD + 1);
    localparam int OFF_W  = $clog2(MAX_PAYLOAD + 1);
    localparam int SEQ_W  = (FRAGMENTS > 1) ? $clog2(FRAGMENTS) : 1;
    localparam int CNT_W  = $clog2(FRAGMENTS + 1);
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int QC_W   = $clog2(SLOTS + 1);
    localparam int LEN_D  = SLOTS * FRAGMENTS;
    localparam int PAY_D  = SLOTS * FRAGMENTS * MAX_PAYLOAD;
    localparam int LEN_AW = (LEN_D > 1) ? $clog2(LEN_D) : 1;
    localparam int PAY_AW = (PAY_D > 1) ? $clog2(PAY_D) : 1;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_EVICT = 8'b00000010,
        S_ALLOC = 8'b00000100,
        S_END   = 8'b00001000,
        S_FIND  = 8'b00010000,
        S_FCHK  = 8'b00100000,
        S_PCAP  = 8'b01000000,
        S_EMIT  = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    logic [7:0]          hdr_reg [HDR];
    logic [7:0]          hdr_next [HDR];
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [SLOT_W-1:0]   cur_slot_reg, cur_slot_next;
    logic [2:0]          drop_reg, drop_next;
    logic [31:0]         newest_reg, newest_next;
    logic [31:0]         window_reg, window_next;
    logic                end_reg, end_next;

    fra_pkg::slot_status_t slot_st_reg [SLOTS];
    fra_pkg::slot_status_t slot_st_next [SLOTS];
    logic [31:0]         slot_img_reg [SLOTS];
    logic [31:0]         slot_img_next [SLOTS];
    logic                slot_seen_reg [SLOTS];
    logic                slot_seen_next [SLOTS];
    logic [SEQ_W-1:0]    slot_lseq_reg [SLOTS];
    logic [SEQ_W-1:0]    slot_lseq_next [SLOTS];
    logic [FRAGMENTS-1:0] slot_map_reg [SLOTS];
    logic [FRAGMENTS-1:0] slot_map_next [SLOTS];
    logic [CNT_W-1:0]    slot_cnt_reg [SLOTS];
    logic [CNT_W-1:0]    slot_cnt_next [SLOTS];

    logic [SLOT_W-1:0]   queue_reg [SLOTS];
    logic [SLOT_W-1:0]   queue_next [SLOTS];
    logic [SLOT_W-1:0]   qhead_reg, qhead_next;
    logic [QC_W-1:0]     qcnt_reg, qcnt_next;
    logic [SEQ_W-1:0]    rseq_reg, rseq_next;
    logic [OFF_W-1:0]    roff_reg, roff_next;

    logic [SLOT_W-1:0]   fslot_reg, fslot_next;
    logic [SEQ_W:0]      fseq_reg, fseq_next;
    logic [OFF_W-1:0]    foff_reg, foff_next;
    logic                fnext_reg, fnext_next;

    logic                pkind_reg, pkind_next;
    logic [7:0]          pbyte_reg, pbyte_next;
    logic                plast_reg, plast_next;
    logic [31:0]         pimg_reg, pimg_next;
    logic [2:0]          preason_reg, preason_next;

    logic                out_valid_reg, out_valid_next;
    logic                okind_reg, okind_next;
    logic [7:0]          obyte_reg, obyte_next;
    logic                olast_reg, olast_next;
    logic [31:0]         oimg_reg, oimg_next;
    logic [2:0]          oreason_reg, oreason_next;

    logic                pay_we;
    logic [PAY_AW-1:0]   pay_waddr, pay_raddr;
    logic [7:0]          pay_wdata, pay_rdata;
    logic                len_we;
    logic [LEN_AW-1:0]   len_waddr, len_raddr;
    logic [OFF_W-1:0]    len_wdata, len_rdata;

    logic [31:0]         hdr_img, hdr_seq;
    logic [SEQ_W-1:0]    seq_lo;
    logic                in_acc, cfg_wr;

    assign hdr_img = {hdr_reg[3], hdr_reg[2], hdr_reg[1], hdr_reg[0]};
    assign hdr_seq = {hdr_reg[7], hdr_reg[6], hdr_reg[5], hdr_reg[4]};
    assign seq_lo  = hdr_seq[SEQ_W-1:0];
    assign in_ready = (state_reg == S_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign cfg_wr   = psel && penable && pwrite;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == fra_pkg::REG_WINDOW) ? window_reg : 32'd0;

    assign out_valid   = out_valid_reg;
    assign out_kind    = okind_reg;
    assign out_byte    = obyte_reg;
    assign frame_last  = olast_reg;
    assign frame_image = oimg_reg;
    assign drop_reason = oreason_reg;

    fra_ram #(.WIDTH(8), .DEPTH(PAY_D)) u_pay_ram (
        .clk   (clk),
        .we    (pay_we),
        .waddr (pay_waddr),
        .wdata (pay_wdata),
        .raddr (pay_raddr),
        .rdata (pay_rdata)
    );

    fra_ram #(.WIDTH(OFF_W), .DEPTH(LEN_D)) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (len_waddr),
        .wdata (len_wdata),
        .raddr (len_raddr),
        .rdata (len_rdata)
    );

    // main sequencer
    always_comb
    begin
        logic [POS_W-1:0]  off;
        logic              hit;
        logic [31:0]       nw;
        logic [CNT_W-1:0]  cnt_n;
        logic              seen_n;
        logic [SEQ_W-1:0]  lseq_n;
        logic [FRAGMENTS-1:0] map_n;
        logic [QC_W:0]     qidx;
        logic [SLOT_W-1:0] s;

        state_next    = state_reg;
        hdr_next      = hdr_reg;
        pos_next      = pos_reg;
        cur_slot_next = cur_slot_reg;
        drop_next     = drop_reg;
        newest_next   = newest_reg;
        window_next   = window_reg;
        end_next      = end_reg;
        slot_st_next   = slot_st_reg;
        slot_img_next  = slot_img_reg;
        slot_seen_next = slot_seen_reg;
        slot_lseq_next = slot_lseq_reg;
        slot_map_next  = slot_map_reg;
        slot_cnt_next  = slot_cnt_reg;
        queue_next    = queue_reg;
        qhead_next    = qhead_reg;
        qcnt_next     = qcnt_reg;
        rseq_next     = rseq_reg;
        roff_next     = roff_reg;
        fslot_next    = fslot_reg;
        fseq_next     = fseq_reg;
        foff_next     = foff_reg;
        fnext_next    = fnext_reg;
        pkind_next    = pkind_reg;
        pbyte_next    = pbyte_reg;
        plast_next    = plast_reg;
        pimg_next     = pimg_reg;
        preason_next  = preason_reg;
        out_valid_next = out_valid_reg && !out_ready;
        okind_next    = okind_reg;
        obyte_next    = obyte_reg;
        olast_next    = olast_reg;
        oimg_next     = oimg_reg;
        oreason_next  = oreason_reg;
        pay_we    = 1'b0;
        pay_wdata = data_byte;
        pay_waddr = PAY_AW'((PAY_AW'(cur_slot_reg) * PAY_AW'(FRAGMENTS) + PAY_AW'(seq_lo))
                    * PAY_AW'(MAX_PAYLOAD) + PAY_AW'(pos_reg - POS_W'(HDR)));
        pay_raddr = PAY_AW'((PAY_AW'(fslot_reg) * PAY_AW'(FRAGMENTS)
                    + PAY_AW'(fseq_reg[SEQ_W-1:0])) * PAY_AW'(MAX_PAYLOAD) + PAY_AW'(foff_reg));
        len_we    = 1'b0;
        len_waddr = LEN_AW'(LEN_AW'(cur_slot_reg) * LEN_AW'(FRAGMENTS) + LEN_AW'(seq_lo));
        len_wdata = OFF_W'(pos_reg - POS_W'(HDR));
        len_raddr = LEN_AW'(LEN_AW'(fslot_reg) * LEN_AW'(FRAGMENTS)
                    + LEN_AW'(fseq_reg[SEQ_W-1:0]));
        off    = pos_reg - POS_W'(HDR);
        hit    = 1'b0;
        nw     = newest_reg;
        cnt_n  = '0;
        seen_n = 1'b0;
        lseq_n = '0;
        map_n  = '0;
        qidx   = '0;
        s      = cur_slot_reg;

        if (cfg_wr && paddr[2] == fra_pkg::REG_WINDOW)
        begin
            window_next = pwdata;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && action == fra_pkg::ACT_TICK)
                begin
                    // start a readout scan at the saved cursor
                    if (qcnt_reg != '0)
                    begin
                        fslot_next = queue_reg[qhead_reg];
                        fseq_next  = {1'b0, rseq_reg};
                        foff_next  = roff_reg;
                        fnext_next = 1'b0;
                        state_next = S_FIND;
                    end
                end
                else if (in_acc)
                begin
                    end_next = packet_end;
                    if (pos_reg < POS_W'(HDR))
                    begin
                        hdr_next[pos_reg[HIW-1:0]] = data_byte;
                        pos_next = pos_reg + 1'b1;
                        if (pos_reg == POS_W'(HDR - 1))
                        begin
                            state_next = S_EVICT;
                        end
                        else if (packet_end)
                        begin
                            state_next = S_END;
                        end
                    end
                    else
                    begin
                        if (drop_reg == fra_pkg::DROP_NONE)
                        begin
                            if (off >= POS_W'(MAX_PAYLOAD))
                            begin
                                // oversize: drop and mark the fragment absent
                                drop_next = fra_pkg::DROP_OVERSIZE;
                                if (slot_map_reg[cur_slot_reg][seq_lo])
                                begin
                                    slot_map_next[cur_slot_reg][seq_lo] = 1'b0;
                                    slot_cnt_next[cur_slot_reg] =
                                        slot_cnt_reg[cur_slot_reg] - 1'b1;
                                end
                            end
                            else
                            begin
                                pay_we   = 1'b1;
                                pos_next = pos_reg + 1'b1;
                            end
                        end
                        if (packet_end)
                        begin
                            state_next = S_END;
                        end
                    end
                end
            end

            S_EVICT:
            begin
                // raise newest image and free lagging frames
                if (hdr_img > newest_reg)
                begin
                    nw = hdr_img;
                end
                newest_next = nw;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_st_reg[i] == fra_pkg::ST_ASSEMBLING && nw > slot_img_reg[i]
                        && (nw - slot_img_reg[i]) > window_reg)
                    begin
                        slot_st_next[i] = fra_pkg::ST_FREE;
                    end
                end
                state_next = S_ALLOC;
            end

            S_ALLOC:
            begin
                // reject an out-of-range sequence, else find the image's slot or open the lowest free one
                if (hdr_seq >= 32'(FRAGMENTS))
                begin
                    drop_next = fra_pkg::DROP_BAD_SEQ;
                end
                else
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!hit && slot_st_reg[i] == fra_pkg::ST_ASSEMBLING
                            && slot_img_reg[i] == hdr_img)
                        begin
                            hit = 1'b1;
                            cur_slot_next = SLOT_W'(i);
                        end
                    end
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!hit && slot_st_reg[i] == fra_pkg::ST_FREE)
                        begin
                            hit = 1'b1;
                            cur_slot_next     = SLOT_W'(i);
                            slot_st_next[i]   = fra_pkg::ST_ASSEMBLING;
                            slot_img_next[i]  = hdr_img;
                            slot_seen_next[i] = 1'b0;
                            slot_lseq_next[i] = '0;
                            slot_map_next[i]  = '0;
                            slot_cnt_next[i]  = '0;
                        end
                    end
                    if (!hit)
                    begin
                        drop_next = fra_pkg::DROP_NO_SLOT;
                    end
                end
                state_next = end_reg ? S_END : S_IDLE;
            end

            S_END:
            begin
                if (pos_reg < POS_W'(HDR) || drop_reg != fra_pkg::DROP_NONE)
                begin
                    pkind_next   = fra_pkg::KIND_DROP;
                    pbyte_next   = 8'd0;
                    plast_next   = 1'b0;
                    pimg_next    = hdr_img;
                    preason_next = (pos_reg < POS_W'(HDR)) ? fra_pkg::DROP_SHORT : drop_reg;
                    state_next   = S_EMIT;
                end
                else
                begin
                    // record the fragment and queue a complete frame
                    len_we = 1'b1;
                    map_n  = slot_map_reg[s];
                    map_n[seq_lo] = 1'b1;
                    cnt_n  = slot_cnt_reg[s] + CNT_W'(!slot_map_reg[s][seq_lo]);
                    seen_n = slot_seen_reg[s] || (hdr_reg[8] != 8'd0);
                    lseq_n = (hdr_reg[8] != 8'd0) ? seq_lo : slot_lseq_reg[s];
                    slot_map_next[s]  = map_n;
                    slot_cnt_next[s]  = cnt_n;
                    slot_seen_next[s] = seen_n;
                    slot_lseq_next[s] = lseq_n;
                    if (seen_n && cnt_n == CNT_W'(lseq_n) + 1'b1
                        && qcnt_reg < QC_W'(SLOTS))
                    begin
                        slot_st_next[s] = fra_pkg::ST_READY;
                        qidx = (QC_W + 1)'(qhead_reg) + (QC_W + 1)'(qcnt_reg);
                        if (qidx >= (QC_W + 1)'(SLOTS))
                        begin
                            qidx = qidx - (QC_W + 1)'(SLOTS);
                        end
                        queue_next[qidx[SLOT_W-1:0]] = s;
                        qcnt_next = qcnt_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
                for (int i = 0; i < HDR; i++)
                begin
                    hdr_next[i] = 8'd0;
                end
                pos_next  = '0;
                drop_next = fra_pkg::DROP_NONE;
            end

            S_FIND:
            begin
                if (fseq_reg >= (SEQ_W + 1)'(FRAGMENTS))
                begin
                    // scan exhausted: free the slot
                    slot_st_next[fslot_reg] = fra_pkg::ST_FREE;
                    qhead_next = (qhead_reg == SLOT_W'(SLOTS - 1)) ? '0 : qhead_reg + 1'b1;
                    qcnt_next  = qcnt_reg - 1'b1;
                    rseq_next  = '0;
                    roff_next  = '0;
                    if (fnext_reg)
                    begin
                        pkind_next   = fra_pkg::KIND_FRAME;
                        plast_next   = 1'b1;
                        pimg_next    = slot_img_reg[fslot_reg];
                        preason_next = fra_pkg::DROP_NONE;
                        state_next   = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (!slot_map_reg[fslot_reg][fseq_reg[SEQ_W-1:0]])
                begin
                    fseq_next = fseq_reg + 1'b1;
                    foff_next = '0;
                end
                else
                begin
                    state_next = S_FCHK;
                end
            end

            S_FCHK:
            begin
                if (foff_reg < len_rdata)
                begin
                    if (!fnext_reg)
                    begin
                        // fetch this byte, then look for the one after it
                        foff_next  = foff_reg + 1'b1;
                        fnext_next = 1'b1;
                        state_next = S_PCAP;
                    end
                    else
                    begin
                        rseq_next    = fseq_reg[SEQ_W-1:0];
                        roff_next    = foff_reg;
                        pkind_next   = fra_pkg::KIND_FRAME;
                        plast_next   = 1'b0;
                        pimg_next    = slot_img_reg[fslot_reg];
                        preason_next = fra_pkg::DROP_NONE;
                        state_next   = S_EMIT;
                    end
                end
                else
                begin
                    fseq_next  = fseq_reg + 1'b1;
                    foff_next  = '0;
                    state_next = S_FIND;
                end
            end

            S_PCAP:
            begin
                pbyte_next = pay_rdata;
                state_next = S_FIND;
            end

            S_EMIT:
            begin
                // hold until the result register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    okind_next     = pkind_reg;
                    obyte_next     = (pkind_reg == fra_pkg::KIND_DROP) ? 8'd0 : pbyte_reg;
                    olast_next     = plast_reg;
                    oimg_next      = pimg_reg;
                    oreason_next   = preason_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            cur_slot_reg  <= '0;
            drop_reg      <= fra_pkg::DROP_NONE;
            newest_reg    <= '0;
            window_reg    <= fra_pkg::WINDOW_RESET;
            end_reg       <= 1'b0;
            qhead_reg     <= '0;
            qcnt_reg      <= '0;
            rseq_reg      <= '0;
            roff_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < HDR; i++)
            begin
                hdr_reg[i] <= 8'd0;
            end
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_st_reg[i]   <= fra_pkg::ST_FREE;
                slot_img_reg[i]  <= '0;
                slot_seen_reg[i] <= 1'b0;
                slot_lseq_reg[i] <= '0;
                slot_map_reg[i]  <= '0;
                slot_cnt_reg[i]  <= '0;
                queue_reg[i]     <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            cur_slot_reg   <= cur_slot_next;
            drop_reg       <= drop_next;
            newest_reg     <= newest_next;
            window_reg     <= window_next;
            end_reg        <= end_next;
            qhead_reg      <= qhead_next;
            qcnt_reg       <= qcnt_next;
            rseq_reg       <= rseq_next;
            roff_reg       <= roff_next;
            out_valid_reg  <= out_valid_next;
            hdr_reg        <= hdr_next;
            slot_st_reg    <= slot_st_next;
            slot_img_reg   <= slot_img_next;
            slot_seen_reg  <= slot_seen_next;
            slot_lseq_reg  <= slot_lseq_next;
            slot_map_reg   <= slot_map_next;
            slot_cnt_reg   <= slot_cnt_next;
            queue_reg      <= queue_next;
        end
    end

    // scan cursor and result payload
    always_ff @(posedge clk)
    begin
        fslot_reg   <= fslot_next;
        fseq_reg    <= fseq_next;
        foff_reg    <= foff_next;
        fnext_reg   <= fnext_next;
        pkind_reg   <= pkind_next;
        pbyte_reg   <= pbyte_next;
        plast_reg   <= plast_next;
        pimg_reg    <= pimg_next;
        preason_reg <= preason_next;
        okind_reg   <= okind_next;
        obyte_reg   <= obyte_next;
        olast_reg   <= olast_next;
        oimg_reg    <= oimg_next;
        oreason_reg <= oreason_next;
    end

endmodule

[hw/rtl/fra_checker.sv]
module fra_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_kind,
    input logic [7:0]  out_byte,
    input logic        frame_last,
    input logic [31:0] frame_image,
    input logic [2:0]  drop_reason
);

    // drop notice carries no frame byte and no last mark
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == fra_pkg::KIND_DROP |-> out_byte == 8'd0 && !frame_last)
    else $error("drop notice with frame data");

    // drop notice names a real reason
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == fra_pkg::KIND_DROP |->
            drop_reason == fra_pkg::DROP_SHORT || drop_reason == fra_pkg::DROP_BAD_SEQ ||
            drop_reason == fra_pkg::DROP_OVERSIZE || drop_reason == fra_pkg::DROP_NO_SLOT)
    else $error("drop notice with bad reason");

    // frame byte has no drop reason
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == fra_pkg::KIND_FRAME |-> drop_reason == fra_pkg::DROP_NONE)
    else $error("frame byte with drop reason");

    // stalled beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(frame_image))
    else $error("stalled output beat changed");

endmodule

bind fragment_reassembler fra_checker u_fra_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_kind    (out_kind),
    .out_byte    (out_byte),
    .frame_last  (frame_last),
    .frame_image (frame_image),
    .drop_reason (drop_reason)
);
